// ----- hdl/u8d_pkg.sv -----
// Package for the UTF-8 byte stream decoder.
// Holds field widths, byte class masks, the status codes and the result record.
// No dependencies.
package u8d_pkg;

   localparam int unsigned CODE_POINT_W  = 21;
   localparam int unsigned BYTE_LENGTH_W = 3;
   localparam int unsigned CHAR_COUNT_W  = 17;
   localparam int unsigned PENDING_W     = 2;

   localparam int unsigned CHAR_COUNT_MAX    = (2 ** CHAR_COUNT_W) - 1;
   localparam int unsigned MAX_CHARS_DEFAULT = 65536;

   localparam logic [7:0] ASCII_MASK = 8'b1000_0000;
   localparam logic [7:0] ASCII_CODE = 8'b0000_0000;
   localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
   localparam logic [7:0] LEAD2_CODE = 8'b1100_0000;
   localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
   localparam logic [7:0] LEAD3_CODE = 8'b1110_0000;
   localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
   localparam logic [7:0] LEAD4_CODE = 8'b1111_0000;
   localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
   localparam logic [7:0] CONT_CODE  = 8'b1000_0000;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_LEAD  = 2'd1,
      STATUS_NO_CONT   = 2'd2,
      STATUS_TRUNCATED = 2'd3
   } status_type;

   typedef struct packed {
      logic [CODE_POINT_W-1:0]  code_point;
      logic [BYTE_LENGTH_W-1:0] byte_length;
      logic [CHAR_COUNT_W-1:0]  char_number;
      logic [BYTE_LENGTH_W-1:0] longest_char;
      status_type               status;
      logic                     string_finished;
   } result_type;

endpackage

// ----- hdl/utf8_byte_stream_decoder_top.sv -----
// Top level of the UTF-8 byte stream decoder.
// Depends on u8d_pkg for widths, byte class masks, status codes and the result record.

// The decoder takes one byte per cycle while req_stall is low and gives at most one
// result per byte. The decode state and the result are both registered, with the byte
// classification, code point assembly, count increment and longest-length compare
// between them. The result side has an output register and one skid register, so a
// byte is still taken while one result waits; req_stall rises only when both are full.
// The character count saturates at MAX_CHARS or at 131071, whichever is smaller.
module utf8_byte_stream_decoder_top #(
   parameter int unsigned MAX_CHARS = u8d_pkg::MAX_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [u8d_pkg::CODE_POINT_W-1:0]  rsp_code_point,
   output logic [u8d_pkg::BYTE_LENGTH_W-1:0] rsp_byte_length,
   output logic [u8d_pkg::CHAR_COUNT_W-1:0]  rsp_char_number,
   output logic [u8d_pkg::BYTE_LENGTH_W-1:0] rsp_longest_char,
   output logic [1:0]  rsp_status,
   output logic        rsp_string_finished
);

   localparam int unsigned CountCapInt = (MAX_CHARS < u8d_pkg::CHAR_COUNT_MAX) ?
                                         MAX_CHARS : u8d_pkg::CHAR_COUNT_MAX;
   localparam logic [u8d_pkg::CHAR_COUNT_W-1:0] CountCap =
      CountCapInt[u8d_pkg::CHAR_COUNT_W-1:0];

   logic [u8d_pkg::PENDING_W-1:0]     pending_ff, pending_in;
   logic [u8d_pkg::BYTE_LENGTH_W-1:0] length_ff, length_in;
   logic [u8d_pkg::CODE_POINT_W-1:0]  partial_ff, partial_in;
   logic [u8d_pkg::CHAR_COUNT_W-1:0]  count_ff, count_in;
   logic [u8d_pkg::BYTE_LENGTH_W-1:0] longest_ff, longest_in;
   logic                              rejected_ff, rejected_in;

   u8d_pkg::result_type result_ff, result_in;
   u8d_pkg::result_type skid_ff, skid_in;
   u8d_pkg::result_type new_result;
   logic                result_valid_ff, result_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic                new_valid;
   logic                accept;
   logic                out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !result_valid_ff || !rsp_stall;

   always_comb begin
      logic [7:0]                        b;
      logic                              eos;
      logic                              do_finish;
      logic                              do_error;
      logic                              do_trunc;
      u8d_pkg::status_type               err_status;
      logic [u8d_pkg::BYTE_LENGTH_W-1:0] len_now;
      logic [u8d_pkg::CODE_POINT_W-1:0]  cp_now;
      logic [u8d_pkg::CHAR_COUNT_W-1:0]  count_next;
      logic [u8d_pkg::BYTE_LENGTH_W-1:0] longest_next;

      b            = req_data_byte;
      eos          = req_end_of_string;
      do_finish    = 1'b0;
      do_error     = 1'b0;
      do_trunc     = 1'b0;
      err_status   = u8d_pkg::STATUS_BAD_LEAD;
      len_now      = length_ff;
      cp_now       = partial_ff;
      pending_in   = pending_ff;
      length_in    = length_ff;
      partial_in   = partial_ff;
      count_in     = count_ff;
      longest_in   = longest_ff;
      rejected_in  = rejected_ff;
      new_valid    = 1'b0;
      new_result   = '0;

      if (accept) begin
         if (rejected_ff) begin
            if (eos) begin
               rejected_in = 1'b0;
               pending_in  = '0;
               length_in   = '0;
               partial_in  = '0;
               count_in    = '0;
               longest_in  = '0;
            end
         end else if (pending_ff == '0) begin
            priority if ((b & u8d_pkg::ASCII_MASK) == u8d_pkg::ASCII_CODE) begin
               len_now   = 3'd1;
               cp_now    = {13'd0, b};
               do_finish = 1'b1;
            end else if ((b & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_CODE) begin
               length_in  = 3'd2;
               partial_in = {16'd0, b[4:0]};
               pending_in = 2'd1;
               do_trunc   = eos;
            end else if ((b & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_CODE) begin
               length_in  = 3'd3;
               partial_in = {17'd0, b[3:0]};
               pending_in = 2'd2;
               do_trunc   = eos;
            end else if ((b & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_CODE) begin
               length_in  = 3'd4;
               partial_in = {18'd0, b[2:0]};
               pending_in = 2'd3;
               do_trunc   = eos;
            end else begin
               do_error   = 1'b1;
               err_status = u8d_pkg::STATUS_BAD_LEAD;
            end
         end else if ((b & u8d_pkg::CONT_MASK) != u8d_pkg::CONT_CODE) begin
            do_error   = 1'b1;
            err_status = u8d_pkg::STATUS_NO_CONT;
         end else begin
            cp_now     = {partial_ff[14:0], b[5:0]};
            partial_in = cp_now;
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               do_finish = 1'b1;
            end else begin
               do_trunc = eos;
            end
         end
      end

      count_next   = (count_ff < CountCap) ? count_ff + 17'd1 : count_ff;
      longest_next = (longest_ff < len_now) ? len_now : longest_ff;

      if (do_finish) begin
         new_valid                  = 1'b1;
         new_result.code_point      = cp_now;
         new_result.byte_length     = len_now;
         new_result.char_number     = count_next;
         new_result.longest_char    = longest_next;
         new_result.status          = u8d_pkg::STATUS_OK;
         new_result.string_finished = eos;
         pending_in                 = '0;
         length_in                  = '0;
         partial_in                 = '0;
         count_in                   = eos ? '0 : count_next;
         longest_in                 = eos ? '0 : longest_next;
      end else if (do_error || do_trunc) begin
         new_valid                  = 1'b1;
         new_result.char_number     = count_ff;
         new_result.longest_char    = longest_ff;
         new_result.status          = do_error ? err_status : u8d_pkg::STATUS_TRUNCATED;
         new_result.string_finished = 1'b1;
         pending_in                 = '0;
         length_in                  = '0;
         partial_in                 = '0;
         count_in                   = '0;
         longest_in                 = '0;
         if (do_error) begin
            rejected_in = !eos;
         end
      end
   end

   always_comb begin
      result_in       = result_ff;
      result_valid_in = result_valid_ff;
      skid_in         = skid_ff;
      skid_valid_in   = skid_valid_ff;
      if (out_free) begin
         result_in       = skid_valid_ff ? skid_ff : new_result;
         result_valid_in = skid_valid_ff || new_valid;
         skid_valid_in   = 1'b0;
      end else if (new_valid) begin
         skid_in       = new_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff      <= '0;
         length_ff       <= '0;
         partial_ff      <= '0;
         count_ff        <= '0;
         longest_ff      <= '0;
         rejected_ff     <= 1'b0;
         result_valid_ff <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         pending_ff      <= pending_in;
         length_ff       <= length_in;
         partial_ff      <= partial_in;
         count_ff        <= count_in;
         longest_ff      <= longest_in;
         rejected_ff     <= rejected_in;
         result_valid_ff <= result_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      skid_ff   <= skid_in;
   end

   assign rsp_valid           = result_valid_ff;
   assign rsp_code_point      = result_ff.code_point;
   assign rsp_byte_length     = result_ff.byte_length;
   assign rsp_char_number     = result_ff.char_number;
   assign rsp_longest_char    = result_ff.longest_char;
   assign rsp_status          = result_ff.status;
   assign rsp_string_finished = result_ff.string_finished;

endmodule

// ----- hdl/u8d_checker.sv -----
// Port-level checker for the UTF-8 byte stream decoder, with its bind statement.
// Depends on u8d_pkg for the status codes and field widths.
module u8d_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [u8d_pkg::CODE_POINT_W-1:0]  rsp_code_point,
   input logic [u8d_pkg::BYTE_LENGTH_W-1:0] rsp_byte_length,
   input logic [u8d_pkg::CHAR_COUNT_W-1:0]  rsp_char_number,
   input logic [u8d_pkg::BYTE_LENGTH_W-1:0] rsp_longest_char,
   input logic [1:0]  rsp_status,
   input logic        rsp_string_finished
);

   // An error or truncated transaction always ends its string.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != u8d_pkg::STATUS_OK) |-> rsp_string_finished)
      else $error("error result does not end the string");

   // Error and truncated transactions carry no character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != u8d_pkg::STATUS_OK)
      |-> (rsp_code_point == '0) && (rsp_byte_length == '0))
      else $error("error result carries character data");

   // A decoded character has a legal length that the running maximum covers.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == u8d_pkg::STATUS_OK)
      |-> (rsp_byte_length != 3'd0) && (rsp_byte_length <= 3'd4)
          && (rsp_longest_char >= rsp_byte_length) && (rsp_char_number != '0))
      else $error("decoded character has inconsistent length or count");

   // A stalled result transaction holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point)
          && $stable(rsp_status) && $stable(rsp_char_number))
      else $error("stalled result changed");

endmodule

bind utf8_byte_stream_decoder_top u8d_checker u_u8d_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_code_point      (rsp_code_point),
   .rsp_byte_length     (rsp_byte_length),
   .rsp_char_number     (rsp_char_number),
   .rsp_longest_char    (rsp_longest_char),
   .rsp_status          (rsp_status),
   .rsp_string_finished (rsp_string_finished)
);
